>>> src/asp_pkg.sv
// Shared types, character and SGR code constants, and the 256-entry palette for the SGR parser.
`timescale 1ns / 1ps
`default_nettype none
package asp_pkg;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  fg_index;
		logic [23:0] fg_rgb;
		logic [7:0]  fg_alpha;
		logic [7:0]  bg_index;
		logic [23:0] bg_rgb;
		logic [7:0]  bg_alpha;
		logic        bold;
		logic        italic;
		logic        underline;
		logic        overline;
		logic        strikethrough;
		logic [1:0]  font_style;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_IGNORE,
		OP_DIGIT,
		OP_APPLY,
		OP_RESET_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] digit;
		logic       first;
		logic       emit;
	} entry_t;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_SEP  = 8'h3B;

	localparam logic [7:0] SGR_RESET         = 8'd0;
	localparam logic [7:0] SGR_BOLD          = 8'd1;
	localparam logic [7:0] SGR_DIM           = 8'd2;
	localparam logic [7:0] SGR_ITALIC        = 8'd3;
	localparam logic [7:0] SGR_UNDERLINE     = 8'd4;
	localparam logic [7:0] SGR_SUB_INDEXED   = 8'd5;
	localparam logic [7:0] SGR_HIDDEN        = 8'd8;
	localparam logic [7:0] SGR_STRIKE        = 8'd9;
	localparam logic [7:0] SGR_BOLD_OFF      = 8'd21;
	localparam logic [7:0] SGR_NORMAL        = 8'd22;
	localparam logic [7:0] SGR_ITALIC_OFF    = 8'd23;
	localparam logic [7:0] SGR_UNDERLINE_OFF = 8'd24;
	localparam logic [7:0] SGR_REVEAL        = 8'd28;
	localparam logic [7:0] SGR_STRIKE_OFF    = 8'd29;
	localparam logic [7:0] SGR_FG_FIRST      = 8'd30;
	localparam logic [7:0] SGR_FG_LAST       = 8'd37;
	localparam logic [7:0] SGR_FG_EXT        = 8'd38;
	localparam logic [7:0] SGR_FG_DEFAULT    = 8'd39;
	localparam logic [7:0] SGR_BG_FIRST      = 8'd40;
	localparam logic [7:0] SGR_BG_LAST       = 8'd47;
	localparam logic [7:0] SGR_BG_EXT        = 8'd48;
	localparam logic [7:0] SGR_BG_DEFAULT    = 8'd49;
	localparam logic [7:0] SGR_OVERLINE      = 8'd53;
	localparam logic [7:0] SGR_OVERLINE_OFF  = 8'd55;

	localparam logic [7:0] CUBE_FIRST = 8'd16;
	localparam logic [7:0] GRAY_FIRST = 8'd232;
	localparam logic [7:0] CUBE_STEP  = 8'd51;

	function automatic logic [23:0] base_color(input logic [3:0] idx);
		logic [23:0] c;
		unique case (idx)
			4'd0:    c = 24'h2E3436;
			4'd1:    c = 24'hCC0000;
			4'd2:    c = 24'h4E9A06;
			4'd3:    c = 24'hC4A000;
			4'd4:    c = 24'h3465A4;
			4'd5:    c = 24'h75507B;
			4'd6:    c = 24'h06989A;
			4'd7:    c = 24'hD3D7CF;
			4'd8:    c = 24'h555753;
			4'd9:    c = 24'hEF2929;
			4'd10:   c = 24'h8AE234;
			4'd11:   c = 24'hFCE94F;
			4'd12:   c = 24'h729FCF;
			4'd13:   c = 24'hAD7FA8;
			4'd14:   c = 24'h34E2E2;
			default: c = 24'hEEEEEC;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] gray_level(input logic [4:0] step);
		logic [7:0] g;
		unique case (step)
			5'd0:    g = 8'd0;
			5'd1:    g = 8'd11;
			5'd2:    g = 8'd21;
			5'd3:    g = 8'd32;
			5'd4:    g = 8'd43;
			5'd5:    g = 8'd53;
			5'd6:    g = 8'd64;
			5'd7:    g = 8'd74;
			5'd8:    g = 8'd85;
			5'd9:    g = 8'd96;
			5'd10:   g = 8'd106;
			5'd11:   g = 8'd117;
			5'd12:   g = 8'd128;
			5'd13:   g = 8'd138;
			5'd14:   g = 8'd149;
			5'd15:   g = 8'd159;
			5'd16:   g = 8'd170;
			5'd17:   g = 8'd181;
			5'd18:   g = 8'd191;
			5'd19:   g = 8'd202;
			5'd20:   g = 8'd213;
			5'd21:   g = 8'd223;
			5'd22:   g = 8'd234;
			default: g = 8'd244;
		endcase
		return g;
	endfunction

	// Returns one base-6 digit of a value below 216, its quotient by unit, from threshold compares.
	function automatic logic [2:0] div_by(input logic [7:0] v, input logic [7:0] unit);
		logic [2:0] d;
		priority if (v >= 8'(5 * unit)) d = 3'd5;
		else if (v >= 8'(4 * unit)) d = 3'd4;
		else if (v >= 8'(3 * unit)) d = 3'd3;
		else if (v >= 8'(2 * unit)) d = 3'd2;
		else if (v >= unit) d = 3'd1;
		else d = 3'd0;
		return d;
	endfunction

	function automatic logic [23:0] palette(input logic [7:0] idx);
		logic [7:0]  i;
		logic [7:0]  j;
		logic [2:0]  r;
		logic [2:0]  g;
		logic [2:0]  b;
		logic [7:0]  gl;
		logic [23:0] c;
		i  = idx - CUBE_FIRST;
		r  = div_by(i, 8'd36);
		j  = i - 8'(r * 8'd36);
		g  = div_by(j, 8'd6);
		b  = 3'(j - 8'(g * 8'd6));
		gl = gray_level(5'(idx - GRAY_FIRST));
		priority if (idx < CUBE_FIRST) c = base_color(idx[3:0]);
		else if (idx < GRAY_FIRST)
			c = {8'(CUBE_STEP * r), 8'(CUBE_STEP * g), 8'(CUBE_STEP * b)};
		else c = {gl, gl, gl};
		return c;
	endfunction

endpackage
`default_nettype wire

>>> src/asp_front.sv
// Front end: accepts characters, tracks sequence start and classifies each item for the queue.
`timescale 1ns / 1ps
`default_nettype none
module asp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire asp_pkg::in_item_t in_item,
	input  wire logic              q_ready,
	output logic                   push,
	output asp_pkg::entry_t        push_entry
);
	import asp_pkg::*;

	logic in_seq_q;
	logic is_digit;

	assign in_ready = q_ready;
	assign push     = in_valid && q_ready;
	assign is_digit = (in_item.symbol >= CHAR_ZERO) && (in_item.symbol <= CHAR_NINE);

	always_comb begin
		push_entry.first = !in_seq_q;
		push_entry.emit  = in_item.last;
		push_entry.digit = 4'(in_item.symbol - CHAR_ZERO);
		priority if (!in_seq_q && in_item.last) push_entry.op = OP_RESET_EMIT;
		else if (is_digit) push_entry.op = OP_DIGIT;
		else if (in_item.symbol == CHAR_SEP || in_item.last) push_entry.op = OP_APPLY;
		else push_entry.op = OP_IGNORE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seq_q <= 1'b0;
		end else if (push) begin
			in_seq_q <= !in_item.last;
		end
	end

endmodule
`default_nettype wire

>>> src/asp_queue.sv
// Two-entry queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module asp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire asp_pkg::entry_t push_entry,
	output logic                 q_ready,
	output logic                 q_valid,
	output asp_pkg::entry_t      q_entry,
	input  wire logic            pop
);
	import asp_pkg::*;

	entry_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign q_ready = count_q != QCNT_W'(QDEPTH);
	assign q_valid = count_q != '0;
	assign q_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("Queue count exceeds its depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Queue count did not grow on a push without a pop.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("Queue count did not shrink on a pop without a push.");

endmodule
`default_nettype wire

>>> src/asp_back.sv
// Back end: builds codes, applies them to the attribute state and registers each result item.
`timescale 1ns / 1ps
`default_nettype none
module asp_back #(
	parameter int CODE_BITS = 10
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire asp_pkg::entry_t q_entry,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output asp_pkg::out_item_t   out_item
);
	import asp_pkg::*;

	localparam int ACC_W = CODE_BITS + 4;
	localparam logic [CODE_BITS-1:0] CODE_MAX = '1;

	typedef enum logic [1:0] {ALPHA_OPAQUE, ALPHA_DIM, ALPHA_HIDDEN} alpha_mode_t;
	typedef enum logic [1:0] {EXT_IDLE, EXT_ARMED, EXT_INDEX} ext_mode_t;

	logic [7:0]           fore_index_q, fore_index_n;
	alpha_mode_t          fore_alpha_q, fore_alpha_n;
	logic [7:0]           back_index_q, back_index_n;
	logic                 back_present_q, back_present_n;
	logic                 bold_q, bold_n;
	logic                 italic_q, italic_n;
	logic                 underline_q, underline_n;
	logic                 overline_q, overline_n;
	logic                 strike_q, strike_n;
	logic [CODE_BITS-1:0] param_q, param_n;
	ext_mode_t            fext_q, fext_n;
	ext_mode_t            bext_q, bext_n;

	logic [CODE_BITS-1:0] code;
	ext_mode_t            fext;
	ext_mode_t            bext;
	logic [ACC_W-1:0]     acc;
	logic                 code_small;
	logic [7:0]           lo;
	logic                 out_valid_q;
	out_item_t            out_q;
	out_item_t            result;

	assign pop       = q_valid && (!q_entry.emit || !out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign code       = q_entry.first ? '0 : param_q;
	assign fext       = q_entry.first ? EXT_IDLE : fext_q;
	assign bext       = q_entry.first ? EXT_IDLE : bext_q;
	assign acc        = ACC_W'(code) * ACC_W'(10) + ACC_W'(q_entry.digit);
	assign code_small = (code >> 8) == '0;
	assign lo         = code[7:0];

	always_comb begin
		fore_index_n   = fore_index_q;
		fore_alpha_n   = fore_alpha_q;
		back_index_n   = back_index_q;
		back_present_n = back_present_q;
		bold_n         = bold_q;
		italic_n       = italic_q;
		underline_n    = underline_q;
		overline_n     = overline_q;
		strike_n       = strike_q;
		param_n        = code;
		fext_n         = fext;
		bext_n         = bext;
		unique case (q_entry.op)
			OP_RESET_EMIT: begin
				fore_index_n   = '0;
				fore_alpha_n   = ALPHA_OPAQUE;
				back_index_n   = '0;
				back_present_n = 1'b0;
				bold_n         = 1'b0;
				italic_n       = 1'b0;
				underline_n    = 1'b0;
				overline_n     = 1'b0;
				strike_n       = 1'b0;
			end
			OP_DIGIT: begin
				param_n = (acc > ACC_W'(CODE_MAX)) ? CODE_MAX : CODE_BITS'(acc);
			end
			OP_APPLY: begin
				param_n = '0;
				priority if (fext == EXT_INDEX) begin
					if (code_small) begin
						fore_index_n = lo;
						fore_alpha_n = ALPHA_OPAQUE;
					end
					fext_n = EXT_IDLE;
				end else if (bext == EXT_INDEX) begin
					if (code_small) begin
						back_index_n   = lo;
						back_present_n = 1'b1;
					end
					bext_n = EXT_IDLE;
				end else if (fext == EXT_ARMED && code_small && lo == SGR_SUB_INDEXED) begin
					fext_n = EXT_INDEX;
				end else if (bext == EXT_ARMED && code_small && lo == SGR_SUB_INDEXED) begin
					bext_n = EXT_INDEX;
				end else if (code_small && lo >= SGR_FG_FIRST && lo <= SGR_FG_LAST) begin
					fore_index_n = lo - SGR_FG_FIRST;
					fore_alpha_n = ALPHA_OPAQUE;
				end else if (code_small && lo >= SGR_BG_FIRST && lo <= SGR_BG_LAST) begin
					back_index_n   = lo - SGR_BG_FIRST;
					back_present_n = 1'b1;
				end else if (code_small) begin
					unique case (lo)
						SGR_RESET: begin
							fore_index_n   = '0;
							fore_alpha_n   = ALPHA_OPAQUE;
							back_index_n   = '0;
							back_present_n = 1'b0;
							bold_n         = 1'b0;
							italic_n       = 1'b0;
							underline_n    = 1'b0;
							overline_n     = 1'b0;
							strike_n       = 1'b0;
						end
						SGR_BOLD:          bold_n = 1'b1;
						SGR_BOLD_OFF:      bold_n = 1'b0;
						SGR_DIM:           fore_alpha_n = ALPHA_DIM;
						SGR_NORMAL:        fore_alpha_n = ALPHA_OPAQUE;
						SGR_ITALIC:        italic_n = 1'b1;
						SGR_ITALIC_OFF:    italic_n = 1'b0;
						SGR_UNDERLINE:     underline_n = 1'b1;
						SGR_UNDERLINE_OFF: underline_n = 1'b0;
						SGR_HIDDEN:        fore_alpha_n = ALPHA_HIDDEN;
						SGR_REVEAL:        fore_alpha_n = ALPHA_OPAQUE;
						SGR_STRIKE:        strike_n = 1'b1;
						SGR_STRIKE_OFF:    strike_n = 1'b0;
						SGR_OVERLINE:      overline_n = 1'b1;
						SGR_OVERLINE_OFF:  overline_n = 1'b0;
						SGR_FG_DEFAULT: begin
							fore_index_n = '0;
							fore_alpha_n = ALPHA_OPAQUE;
						end
						SGR_BG_DEFAULT: begin
							back_index_n   = '0;
							back_present_n = 1'b0;
						end
						SGR_FG_EXT:        fext_n = EXT_ARMED;
						SGR_BG_EXT:        bext_n = EXT_ARMED;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		if (q_entry.emit) param_n = '0;
	end

	always_comb begin
		result.fg_index = fore_index_n;
		result.fg_rgb   = palette(fore_index_n);
		unique case (fore_alpha_n)
			ALPHA_OPAQUE: result.fg_alpha = 8'd255;
			ALPHA_DIM:    result.fg_alpha = 8'd128;
			default:      result.fg_alpha = 8'd0;
		endcase
		result.bg_index      = back_present_n ? back_index_n : 8'd0;
		result.bg_rgb        = back_present_n ? palette(back_index_n) : 24'd0;
		result.bg_alpha      = back_present_n ? 8'd255 : 8'd0;
		result.bold          = bold_n;
		result.italic        = italic_n;
		result.underline     = underline_n;
		result.overline      = overline_n;
		result.strikethrough = strike_n;
		result.font_style    = {italic_n, bold_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_index_q   <= '0;
			fore_alpha_q   <= ALPHA_OPAQUE;
			back_index_q   <= '0;
			back_present_q <= 1'b0;
			bold_q         <= 1'b0;
			italic_q       <= 1'b0;
			underline_q    <= 1'b0;
			overline_q     <= 1'b0;
			strike_q       <= 1'b0;
			param_q        <= '0;
			fext_q         <= EXT_IDLE;
			bext_q         <= EXT_IDLE;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				fore_index_q   <= fore_index_n;
				fore_alpha_q   <= fore_alpha_n;
				back_index_q   <= back_index_n;
				back_present_q <= back_present_n;
				bold_q         <= bold_n;
				italic_q       <= italic_n;
				underline_q    <= underline_n;
				overline_q     <= overline_n;
				strike_q       <= strike_n;
				param_q        <= param_n;
				fext_q         <= fext_n;
				bext_q         <= bext_n;
			end
			if (pop && q_entry.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_entry.emit) begin
			out_q <= result;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_entry.emit && out_valid_q && !out_ready) |-> !pop)
		else $error("A result item would overwrite one not yet taken.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_entry.emit) |=> (out_valid_q && param_q == '0))
		else $error("A terminator did not present a result and clear the code.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_entry.op == OP_RESET_EMIT) |=>
			(!out_q.bold && !out_q.italic && out_q.bg_alpha == 8'd0 && out_q.fg_index == 8'd0))
		else $error("A one-item sequence did not clear the attributes.");

endmodule
`default_nettype wire

>>> src/ansi_sgr_attribute_parser.sv
// Top level of the SGR attribute parser: front end, item queue and back end.
// The block takes one character of an SGR parameter string per item, with last set on the
// terminator, and returns one result item per terminator holding the current colors, alphas and
// style flags; attributes persist from one sequence to the next. It sustains one item per clock
// cycle unless a terminator waits on an output register not yet taken; the back end builds or
// applies a code for each item as it pops it. A character reaches the back end through a two-entry
// queue, and a terminator's result passes from its queue slot into the output register, where it
// sits while the block keeps accepting characters; only a second terminator stalls behind it.
// Codes saturate at 2**CODE_BITS-1, and an extended color index above 255 is ignored.
`timescale 1ns / 1ps
`default_nettype none
module ansi_sgr_attribute_parser #(
	parameter int CODE_BITS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire asp_pkg::in_item_t in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output asp_pkg::out_item_t     out_item
);
	import asp_pkg::*;

	logic   push;
	entry_t push_entry;
	logic   q_ready;
	logic   q_valid;
	entry_t q_entry;
	logic   pop;

	asp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.q_ready    (q_ready),
		.push       (push),
		.push_entry (push_entry)
	);

	asp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.pop        (pop)
	);

	asp_back #(
		.CODE_BITS (CODE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

>>> test/ansi_sgr_attribute_parser_test.sv
// Self-checking testbench for the SGR attribute parser, with a directed table and random sequences.
`timescale 1ns / 1ps
module ansi_sgr_attribute_parser_test;
	import asp_pkg::*;

	localparam int CODE_BITS = 10;
	localparam int unsigned CODE_MAX = (1 << CODE_BITS) - 1;
	localparam int unsigned INDEX_MAX = 255;
	localparam int unsigned ITEM_TARGET = 2000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [7:0] CHAR_FINAL = 8'h6D;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_DIM = 8'd128;
	localparam logic [7:0] ALPHA_HIDDEN = 8'd0;

	typedef enum logic [1:0] {FG_OPAQUE, FG_DIM, FG_HIDDEN} fg_shade_t;
	typedef enum logic [1:0] {EXT_IDLE, EXT_PREFIX, EXT_INDEXED} ext_stage_t;

	typedef struct {
		logic [7:0] symbol;
		logic       last;
		bit         typed;
		out_item_t  attrs;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	logic [7:0]           fore_idx;
	logic [7:0]           back_idx;
	fg_shade_t            fore_shade;
	logic                 back_on;
	logic                 bold_on;
	logic                 italic_on;
	logic                 underline_on;
	logic                 overline_on;
	logic                 strike_on;
	logic                 in_seq;
	logic [CODE_BITS-1:0] code_acc;
	ext_stage_t           fore_ext;
	ext_stage_t           back_ext;

	out_item_t    pending_attrs[$];
	stim_row_t    directed_rows[$];
	logic [7:0]   seq_chars[$];
	int unsigned  attr_codes[$];
	int unsigned  items_sent = 0;
	int unsigned  results_seen = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;
	bit           hold_request = 1'b0;
	bit           hold_done = 1'b0;

	ansi_sgr_attribute_parser #(
		.CODE_BITS(CODE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [23:0] xterm_rgb(input logic [7:0] idx);
		int unsigned i;
		int unsigned g;
		logic [23:0] c;
		if (idx < CUBE_FIRST) begin
			case (idx[3:0])
				4'd0:    c = 24'h2E3436;
				4'd1:    c = 24'hCC0000;
				4'd2:    c = 24'h4E9A06;
				4'd3:    c = 24'hC4A000;
				4'd4:    c = 24'h3465A4;
				4'd5:    c = 24'h75507B;
				4'd6:    c = 24'h06989A;
				4'd7:    c = 24'hD3D7CF;
				4'd8:    c = 24'h555753;
				4'd9:    c = 24'hEF2929;
				4'd10:   c = 24'h8AE234;
				4'd11:   c = 24'hFCE94F;
				4'd12:   c = 24'h729FCF;
				4'd13:   c = 24'hAD7FA8;
				4'd14:   c = 24'h34E2E2;
				default: c = 24'hEEEEEC;
			endcase
		end else if (idx < GRAY_FIRST) begin
			i = idx - CUBE_FIRST;
			c = {8'(CUBE_STEP * (i / 36)), 8'(CUBE_STEP * ((i / 6) % 6)), 8'(CUBE_STEP * (i % 6))};
		end else begin
			g = (255 * (idx - GRAY_FIRST) + 12) / 24;
			c = {3{8'(g)}};
		end
		return c;
	endfunction

	function automatic void clear_attrs();
		fore_idx = '0;
		fore_shade = FG_OPAQUE;
		back_idx = '0;
		back_on = 1'b0;
		bold_on = 1'b0;
		italic_on = 1'b0;
		underline_on = 1'b0;
		overline_on = 1'b0;
		strike_on = 1'b0;
	endfunction

	function automatic void apply_code(input int unsigned code);
		if (fore_ext == EXT_INDEXED) begin
			if (code <= INDEX_MAX) begin
				fore_idx = 8'(code);
				fore_shade = FG_OPAQUE;
			end
			fore_ext = EXT_IDLE;
		end else if (back_ext == EXT_INDEXED) begin
			if (code <= INDEX_MAX) begin
				back_idx = 8'(code);
				back_on = 1'b1;
			end
			back_ext = EXT_IDLE;
		end else if (fore_ext == EXT_PREFIX && code == SGR_SUB_INDEXED) begin
			fore_ext = EXT_INDEXED;
		end else if (back_ext == EXT_PREFIX && code == SGR_SUB_INDEXED) begin
			back_ext = EXT_INDEXED;
		end else if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
			fore_idx = 8'(code - SGR_FG_FIRST);
			fore_shade = FG_OPAQUE;
		end else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST) begin
			back_idx = 8'(code - SGR_BG_FIRST);
			back_on = 1'b1;
		end else begin
			case (code)
				SGR_RESET:         clear_attrs();
				SGR_BOLD:          bold_on = 1'b1;
				SGR_BOLD_OFF:      bold_on = 1'b0;
				SGR_DIM:           fore_shade = FG_DIM;
				SGR_NORMAL:        fore_shade = FG_OPAQUE;
				SGR_ITALIC:        italic_on = 1'b1;
				SGR_ITALIC_OFF:    italic_on = 1'b0;
				SGR_UNDERLINE:     underline_on = 1'b1;
				SGR_UNDERLINE_OFF: underline_on = 1'b0;
				SGR_HIDDEN:        fore_shade = FG_HIDDEN;
				SGR_REVEAL:        fore_shade = FG_OPAQUE;
				SGR_STRIKE:        strike_on = 1'b1;
				SGR_STRIKE_OFF:    strike_on = 1'b0;
				SGR_OVERLINE:      overline_on = 1'b1;
				SGR_OVERLINE_OFF:  overline_on = 1'b0;
				SGR_FG_DEFAULT: begin
					fore_idx = '0;
					fore_shade = FG_OPAQUE;
				end
				SGR_BG_DEFAULT: begin
					back_idx = '0;
					back_on = 1'b0;
				end
				SGR_FG_EXT:        fore_ext = EXT_PREFIX;
				SGR_BG_EXT:        back_ext = EXT_PREFIX;
				default: ;
			endcase
		end
	endfunction

	// Advances the attribute state by one character; returns 1 when a terminator yields a result.
	function automatic bit sgr_step(input in_item_t it, output out_item_t res);
		int unsigned v;
		res = '0;
		if (!in_seq) begin
			code_acc = '0;
			fore_ext = EXT_IDLE;
			back_ext = EXT_IDLE;
		end
		if (!in_seq && it.last) begin
			clear_attrs();
		end else if (it.symbol >= CHAR_ZERO && it.symbol <= CHAR_NINE) begin
			v = code_acc * 10 + (it.symbol - CHAR_ZERO);
			code_acc = (v > CODE_MAX) ? CODE_MAX[CODE_BITS-1:0] : v[CODE_BITS-1:0];
		end else if (it.symbol == CHAR_SEP || it.last) begin
			apply_code(code_acc);
			code_acc = '0;
		end
		if (!it.last) begin
			in_seq = 1'b1;
			return 1'b0;
		end
		in_seq = 1'b0;
		code_acc = '0;
		res.fg_index = fore_idx;
		res.fg_rgb = xterm_rgb(fore_idx);
		case (fore_shade)
			FG_OPAQUE: res.fg_alpha = ALPHA_OPAQUE;
			FG_DIM:    res.fg_alpha = ALPHA_DIM;
			default:   res.fg_alpha = ALPHA_HIDDEN;
		endcase
		res.bg_index = back_on ? back_idx : 8'd0;
		res.bg_rgb = back_on ? xterm_rgb(back_idx) : 24'd0;
		res.bg_alpha = back_on ? ALPHA_OPAQUE : ALPHA_HIDDEN;
		res.bold = bold_on;
		res.italic = italic_on;
		res.underline = underline_on;
		res.overline = overline_on;
		res.strikethrough = strike_on;
		res.font_style = {italic_on, bold_on};
		return 1'b1;
	endfunction

	function automatic out_item_t fg_only_attrs(input logic [7:0] idx, input logic [23:0] rgb,
		input logic [7:0] alpha);
		out_item_t res;
		res = '0;
		res.fg_index = idx;
		res.fg_rgb = rgb;
		res.fg_alpha = alpha;
		return res;
	endfunction

	function automatic void add_row(input logic [7:0] sym, input logic last, input bit typed,
		input out_item_t attrs);
		stim_row_t row;
		row.symbol = sym;
		row.last = last;
		row.typed = typed;
		row.attrs = attrs;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_text(input string s, input logic [7:0] term, input bit typed,
		input out_item_t attrs);
		for (int i = 0; i < s.len(); i++)
			add_row(s[i], 1'b0, 1'b0, '0);
		add_row(term, 1'b1, typed, attrs);
	endfunction

	function automatic int unsigned gap_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] stray_char();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_SEP);
		return c;
	endfunction

	function automatic void push_number(input int unsigned n);
		string s;
		s = $sformatf("%0d", n);
		if ($urandom_range(0, 7) == 0)
			seq_chars.push_back(CHAR_ZERO);
		for (int i = 0; i < s.len(); i++)
			seq_chars.push_back(s[i]);
	endfunction

	function automatic void append_param();
		int unsigned pick;
		int unsigned reps;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			return;
		end else if (pick < 10) begin
			reps = $urandom_range(5, 7);
			repeat (reps) seq_chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
		end else if (pick < 25) begin
			push_number($urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT);
			if ($urandom_range(0, 9) == 0)
				return;
			seq_chars.push_back(CHAR_SEP);
			push_number(($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : SGR_SUB_INDEXED);
			seq_chars.push_back(CHAR_SEP);
			push_number(($urandom_range(0, 7) == 0) ? $urandom_range(256, CODE_MAX)
				: $urandom_range(0, INDEX_MAX));
		end else if (pick < 55) begin
			push_number(attr_codes[$urandom_range(0, attr_codes.size() - 1)]);
		end else if (pick < 75) begin
			push_number($urandom_range(SGR_FG_FIRST, SGR_BG_LAST));
		end else if (pick < 90) begin
			push_number($urandom_range(0, 99));
		end else begin
			push_number($urandom_range(0, CODE_MAX));
		end
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("mismatch at cycle %0d, result %0d: %s", cycle_count, results_seen, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (pending_attrs.size() == 0) begin
			report_mismatch("result item with no terminator waiting");
		end else begin
			want = pending_attrs.pop_front();
			check_field("fg_index", got.fg_index, want.fg_index);
			check_field("fg_rgb", got.fg_rgb, want.fg_rgb);
			check_field("fg_alpha", got.fg_alpha, want.fg_alpha);
			check_field("bg_index", got.bg_index, want.bg_index);
			check_field("bg_rgb", got.bg_rgb, want.bg_rgb);
			check_field("bg_alpha", got.bg_alpha, want.bg_alpha);
			check_field("bold", got.bold, want.bold);
			check_field("italic", got.italic, want.italic);
			check_field("underline", got.underline, want.underline);
			check_field("overline", got.overline, want.overline);
			check_field("strikethrough", got.strikethrough, want.strikethrough);
			check_field("font_style", got.font_style, want.font_style);
		end
		results_seen++;
	endtask

	task automatic send_char(input logic [7:0] sym, input logic last, input bit burst,
		input bit typed, input out_item_t typed_attrs);
		in_item_t it;
		out_item_t predicted;
		int unsigned gap;
		it.symbol = sym;
		it.last = last;
		gap = burst ? 0 : gap_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (sgr_step(it, predicted))
			pending_attrs.push_back(typed ? typed_attrs : predicted);
	endtask

	task automatic send_random_sequence();
		int unsigned n_params;
		int unsigned n_noise;
		bit burst;
		logic [7:0] term;
		seq_chars.delete();
		burst = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) == 0) begin
			n_noise = $urandom_range(1, 6);
			repeat (n_noise) seq_chars.push_back(8'($urandom));
			term = seq_chars.pop_back();
		end else begin
			n_params = $urandom_range(0, 5);
			for (int p = 0; p < n_params; p++) begin
				if (p > 0)
					seq_chars.push_back(CHAR_SEP);
				append_param();
				if ($urandom_range(0, 19) == 0)
					seq_chars.push_back(stray_char());
			end
			case ($urandom_range(0, 9))
				0:       term = 8'($urandom);
				1:       term = 8'(CHAR_ZERO + $urandom_range(0, 9));
				default: term = CHAR_FINAL;
			endcase
		end
		foreach (seq_chars[k])
			send_char(seq_chars[k], 1'b0, burst, 1'b0, '0);
		send_char(term, 1'b1, burst, 1'b0, '0);
	endtask

	// Withdraws the last offered item before waiting, so it is not taken a second time.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_attrs.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned high_len;
		int unsigned low_len;
		out_ready = 1'b0;
		forever begin
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				high_len = 0;
				low_len = HOLD_CYCLES;
			end else if ($urandom_range(0, 4) == 0) begin
				high_len = $urandom_range(50, 200);
				low_len = 0;
			end else begin
				high_len = $urandom_range(1, 8);
				low_len = gap_len();
			end
			repeat (high_len) @(negedge clk) out_ready <= 1'b1;
			repeat (low_len) @(negedge clk) out_ready <= 1'b0;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_result(out_item);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles.", cycle_count);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		clear_attrs();
		code_acc = '0;
		fore_ext = EXT_IDLE;
		back_ext = EXT_IDLE;
		in_seq = 1'b0;
		attr_codes = '{SGR_RESET, SGR_BOLD, SGR_DIM, SGR_ITALIC, SGR_UNDERLINE, SGR_SUB_INDEXED,
			SGR_HIDDEN, SGR_STRIKE, SGR_BOLD_OFF, SGR_NORMAL, SGR_ITALIC_OFF, SGR_UNDERLINE_OFF,
			SGR_REVEAL, SGR_STRIKE_OFF, SGR_FG_EXT, SGR_FG_DEFAULT, SGR_BG_EXT, SGR_BG_DEFAULT,
			SGR_OVERLINE, SGR_OVERLINE_OFF};

		// A lone terminator resets everything to the default look.
		add_text("", CHAR_FINAL, 1'b1, fg_only_attrs(8'd0, 24'h2E3436, ALPHA_OPAQUE));
		add_text("38;5;255", CHAR_FINAL, 1'b1, fg_only_attrs(8'd255, 24'hF4F4F4, ALPHA_OPAQUE));
		// An oversized background index is dropped after the code saturates.
		add_text("2;48;5;99999", 8'hFF, 1'b1, fg_only_attrs(8'd255, 24'hF4F4F4, ALPHA_DIM));
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(CHAR_ZERO, 1'b1, 1'b0, '0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r])
			send_char(directed_rows[r].symbol, directed_rows[r].last, 1'b0,
				directed_rows[r].typed, directed_rows[r].attrs);
		drain_results();

		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= 400)
				hold_request = 1'b1;
			if (items_sent >= 1200 && items_sent < 1230)
				drain_results();
			send_random_sequence();
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_attrs.size() != 0)
			report_mismatch("results still missing at the end of the run");
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
